FILE: rtl/core/isg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// isg_pkg
// Shared types and constants for the Ising lattice site-update block:
// command codes, configuration register indexes and lattice port controls.
// ============================================================================
package isg_pkg;

    // Width that holds any lattice size, configured or built (up to 511)
    localparam int SIZE_W = 9;

    // Command codes; the unused code behaves as a read
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic [2:0] CFG_ROWS      = 3'd0;
    localparam logic [2:0] CFG_COLS      = 3'd1;
    localparam logic [2:0] CFG_ACC_M4    = 3'd2;
    localparam logic [2:0] CFG_ACC_M2    = 3'd3;
    localparam logic [2:0] CFG_ACC_ZERO  = 3'd4;
    localparam logic [2:0] CFG_ACC_P2    = 3'd5;
    localparam logic [2:0] CFG_ACC_P4    = 3'd6;

    // Number of acceptance threshold pairs (neighbour sums -4, -2, 0, +2, +4)
    localparam int NUM_THR = 5;

    // Lattice store controls
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_lat_ctrl;

endpackage

FILE: rtl/core/isg_lattice.sv
`timescale 1ns / 1ps
// ============================================================================
// isg_lattice
// Spin lattice held as rows of one-bit spins, in three identical copies so
// that the row above, the site row and the row below can be read in the same cycle.
// Read data is registered; a row written on the same edge is forwarded.
// ============================================================================
module isg_lattice #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                        i_clk,
    input  isg_pkg::t_lat_ctrl          i_ctrl,
    input  logic [$clog2(MAX_ROWS)-1:0] i_rd_row_up,
    input  logic [$clog2(MAX_ROWS)-1:0] i_rd_row_mid,
    input  logic [$clog2(MAX_ROWS)-1:0] i_rd_row_dn,
    input  logic [$clog2(MAX_ROWS)-1:0] i_wr_row,
    input  logic [MAX_COLS-1:0]         i_wr_data,
    output logic [MAX_COLS-1:0]         o_row_up,
    output logic [MAX_COLS-1:0]         o_row_mid,
    output logic [MAX_COLS-1:0]         o_row_dn
);

    logic [MAX_COLS-1:0] r_mem_up  [MAX_ROWS];
    logic [MAX_COLS-1:0] r_mem_mid [MAX_ROWS];
    logic [MAX_COLS-1:0] r_mem_dn  [MAX_ROWS];

    logic [MAX_COLS-1:0] r_row_up;
    logic [MAX_COLS-1:0] r_row_mid;
    logic [MAX_COLS-1:0] r_row_dn;

    // Copy serving the row above the site
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem_up[i_wr_row] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            if (i_ctrl.wr_en && (i_wr_row == i_rd_row_up)) begin
                r_row_up <= i_wr_data;
            end else begin
                r_row_up <= r_mem_up[i_rd_row_up];
            end
        end
    end

    // Copy serving the site row
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem_mid[i_wr_row] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            if (i_ctrl.wr_en && (i_wr_row == i_rd_row_mid)) begin
                r_row_mid <= i_wr_data;
            end else begin
                r_row_mid <= r_mem_mid[i_rd_row_mid];
            end
        end
    end

    // Copy serving the row below the site
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem_dn[i_wr_row] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            if (i_ctrl.wr_en && (i_wr_row == i_rd_row_dn)) begin
                r_row_dn <= i_wr_data;
            end else begin
                r_row_dn <= r_mem_dn[i_rd_row_dn];
            end
        end
    end

    assign o_row_up  = r_row_up;
    assign o_row_mid = r_row_mid;
    assign o_row_dn  = r_row_dn;

endmodule

FILE: rtl/core/ising_metropolis_site_update_top.sv
`timescale 1ns / 1ps
// A command transfers into stage one, whose row words are read into registers on that edge;
// its result moves on into the output register when that register is free.
// Throughput: one command per cycle unless results stall; the three row copies each give
// one read per cycle and the single row write-back is forwarded to a read on the same edge.
// Reset: synchronous, active low; clears control state and restores the lattice size to
// 64 x 64 and all thresholds to 0. Spins are undefined until written; no clearing pass.
// ============================================================================
// ising_metropolis_site_update_top
// Two-dimensional Ising lattice with toroidal wraparound. Commands write a spin,
// read a spin, or make one Metropolis update: the four neighbour spins select a
// threshold pair, the site spin selects one half and the spin flips when the
// random draw is below it.
// ============================================================================
module ising_metropolis_site_update_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Command channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [5:0]        i_site_row,
    input  logic [5:0]        i_site_col,
    input  logic              i_spin_value,
    input  logic [30:0]       i_random_draw,
    // Result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_spin_after,
    output logic              o_flipped,
    output logic signed [3:0] o_neighbor_total,
    output logic              o_status,
    // Configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data
);

    localparam int SW  = isg_pkg::SIZE_W;
    localparam int RAW = $clog2(MAX_ROWS);
    localparam int CAW = $clog2(MAX_COLS);

    // Configuration registers
    logic [6:0]  r_rows_in_use;
    logic [6:0]  r_cols_in_use;
    logic [63:0] r_accept [isg_pkg::NUM_THR];

    // Stage one: command held against the registered row words
    logic          r_s1_valid;
    logic [1:0]    r_s1_cmd;
    logic [RAW-1:0] r_s1_row;
    logic [5:0]    r_s1_col;
    logic          r_s1_spin;
    logic [30:0]   r_s1_draw;
    logic          r_s1_in_range;

    // Output register
    logic              r_out_valid;
    logic              r_out_spin;
    logic              r_out_flip;
    logic signed [3:0] r_out_total;
    logic              r_out_status;

    logic [SW-1:0]  nr;
    logic [SW-1:0]  nc;
    logic [SW-1:0]  in_row;
    logic [SW-1:0]  in_col;
    logic [SW-1:0]  row_plus;
    logic [SW-1:0]  row_minus;
    logic           in_range;
    logic           s1_adv;
    logic           s1_load;
    logic           in_xfer;

    logic [SW-1:0]  s1_col;
    logic [SW-1:0]  col_plus;
    logic [SW-1:0]  col_minus;
    logic [CAW-1:0] c_idx;
    logic [CAW-1:0] cp_idx;
    logic [CAW-1:0] cm_idx;
    logic [2:0]     ups;
    logic           site_spin;
    logic [63:0]    pair;
    logic [31:0]    thr;
    logic           flip_ok;

    logic              n_spin;
    logic              n_flip;
    logic signed [3:0] n_total;
    logic              n_write;

    isg_pkg::t_lat_ctrl  lat_ctrl;
    logic [MAX_COLS-1:0] row_up;
    logic [MAX_COLS-1:0] row_mid;
    logic [MAX_COLS-1:0] row_dn;
    logic [MAX_COLS-1:0] wr_data;

    // Effective lattice size, saturated to the built size
    assign nr = ({2'b0, r_rows_in_use} > SW'(MAX_ROWS)) ? SW'(MAX_ROWS)
                                                       : {2'b0, r_rows_in_use};
    assign nc = ({2'b0, r_cols_in_use} > SW'(MAX_COLS)) ? SW'(MAX_COLS)
                                                       : {2'b0, r_cols_in_use};

    // Handshake: stage one moves on when the output register is free
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || s1_adv;
    assign o_in_stall = !s1_load;
    assign in_xfer    = i_in_valid && s1_load;

    // Wrapped row neighbours of the incoming site
    assign in_row    = {3'b0, i_site_row};
    assign in_col    = {3'b0, i_site_col};
    assign in_range  = (in_row < nr) && (in_col < nc);
    assign row_plus  = ((in_row + SW'(1)) == nr) ? '0 : in_row + SW'(1);
    assign row_minus = (in_row == '0) ? nr - SW'(1) : in_row - SW'(1);

    // Wrapped column neighbours of the held site
    assign s1_col    = {3'b0, r_s1_col};
    assign col_plus  = ((s1_col + SW'(1)) == nc) ? '0 : s1_col + SW'(1);
    assign col_minus = (s1_col == '0) ? nc - SW'(1) : s1_col - SW'(1);
    assign c_idx     = s1_col[CAW-1:0];
    assign cp_idx    = col_plus[CAW-1:0];
    assign cm_idx    = col_minus[CAW-1:0];

    // Neighbour count and acceptance test
    assign site_spin = row_mid[c_idx];
    assign ups       = 3'(row_up[c_idx]) + 3'(row_dn[c_idx])
                     + 3'(row_mid[cp_idx]) + 3'(row_mid[cm_idx]);
    assign pair      = r_accept[ups];
    assign thr       = site_spin ? pair[31:0] : pair[63:32];
    assign flip_ok   = {1'b0, r_s1_draw} < thr;

    // Result and write-back for the held command
    always_comb begin
        n_spin  = 1'b0;
        n_flip  = 1'b0;
        n_total = 4'sd0;
        n_write = 1'b0;
        wr_data = row_mid;
        if (r_s1_in_range) begin
            case (r_s1_cmd)
                isg_pkg::CMD_WRITE: begin
                    n_spin  = r_s1_spin;
                    n_write = 1'b1;
                end
                isg_pkg::CMD_UPDATE: begin
                    n_flip  = flip_ok;
                    n_spin  = site_spin ^ flip_ok;
                    n_total = $signed(4'({ups, 1'b0}) - 4'd4);
                    n_write = 1'b1;
                end
                default: begin
                    n_spin = site_spin;
                end
            endcase
        end
        wr_data[c_idx] = n_spin;
    end

    assign lat_ctrl.rd_en = in_xfer;
    assign lat_ctrl.wr_en = r_s1_valid && s1_adv && n_write;

    isg_lattice #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_lattice (
        .i_clk        (i_clk),
        .i_ctrl       (lat_ctrl),
        .i_rd_row_up  (row_minus[RAW-1:0]),
        .i_rd_row_mid (in_row[RAW-1:0]),
        .i_rd_row_dn  (row_plus[RAW-1:0]),
        .i_wr_row     (r_s1_row),
        .i_wr_data    (wr_data),
        .o_row_up     (row_up),
        .o_row_mid    (row_mid),
        .o_row_dn     (row_dn)
    );

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= 7'd64;
            r_cols_in_use <= 7'd64;
            for (int k = 0; k < isg_pkg::NUM_THR; k++) begin
                r_accept[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                isg_pkg::CFG_ROWS:     r_rows_in_use <= i_cfg_data[6:0];
                isg_pkg::CFG_COLS:     r_cols_in_use <= i_cfg_data[6:0];
                isg_pkg::CFG_ACC_M4:   r_accept[0]   <= i_cfg_data;
                isg_pkg::CFG_ACC_M2:   r_accept[1]   <= i_cfg_data;
                isg_pkg::CFG_ACC_ZERO: r_accept[2]   <= i_cfg_data;
                isg_pkg::CFG_ACC_P2:   r_accept[3]   <= i_cfg_data;
                isg_pkg::CFG_ACC_P4:   r_accept[4]   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd      <= i_command;
            r_s1_row      <= in_row[RAW-1:0];
            r_s1_col      <= i_site_col;
            r_s1_spin     <= i_spin_value;
            r_s1_draw     <= i_random_draw;
            r_s1_in_range <= in_range;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_spin   <= n_spin;
            r_out_flip   <= n_flip;
            r_out_total  <= n_total;
            r_out_status <= !r_s1_in_range;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_spin_after     = r_out_spin;
    assign o_flipped        = r_out_flip;
    assign o_neighbor_total = r_out_total;
    assign o_status         = r_out_status;

endmodule

FILE: rtl/core/isg_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// isg_checker
// Port-level checks for the Ising site-update block, bound to the top level.
// ============================================================================
module isg_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_spin_after,
    input logic              o_flipped,
    input logic signed [3:0] o_neighbor_total,
    input logic              o_status
);

    // Result channel is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Command side only stalls while a result waits at the output
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("command stalled with empty output");

    // Stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_spin_after)
            && $stable(o_flipped) && $stable(o_neighbor_total) && $stable(o_status))
        else $error("stalled result changed");

    // Site outside the lattice gives a cleared result
    a_outside_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> !o_spin_after && !o_flipped
            && (o_neighbor_total == 4'sd0))
        else $error("outside site with non-zero result");

    // Neighbour sum is one of -4, -2, 0, +2, +4
    a_total_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_neighbor_total == -4'sd4) || (o_neighbor_total == -4'sd2)
            || (o_neighbor_total == 4'sd0) || (o_neighbor_total == 4'sd2)
            || (o_neighbor_total == 4'sd4))
        else $error("illegal neighbour sum");

endmodule

bind ising_metropolis_site_update_top isg_checker u_isg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_spin_after     (o_spin_after),
    .o_flipped        (o_flipped),
    .o_neighbor_total (o_neighbor_total),
    .o_status         (o_status)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the Ising lattice site-update block. Commands are
// queued by a stimulus process, presented by a clocked driver with random
// gaps and checked by a clocked monitor against a cycle-free lattice model
// kept in the bench. The lattice size and the threshold table are changed
// between phases, always with the block drained.
// ============================================================================
module tb_top;

    localparam int LAT_ROWS = 64;
    localparam int LAT_COLS = 64;
    localparam int ITEM_GOAL = 1550;
    localparam int N_PHASES = 8;

    // Command code with no defined meaning (behaves as a read)
    localparam logic [1:0] CMD_SPARE = 2'd3;
    // Register index with nothing behind it
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        spin;
        logic [30:0] draw;
    } t_site_cmd;

    typedef struct packed {
        logic              spin_after;
        logic              flipped;
        logic signed [3:0] nbr_total;
        logic              status;
    } t_site_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_command = '0;
    logic [5:0]        i_site_row = '0;
    logic [5:0]        i_site_col = '0;
    logic              i_spin_value = 1'b0;
    logic [30:0]       i_random_draw = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_spin_after;
    logic              o_flipped;
    logic signed [3:0] o_neighbor_total;
    logic              o_status;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [2:0]        i_cfg_index = '0;
    logic [63:0]       i_cfg_data = '0;

    // Lattice model: spins plus its own copy of the registers
    bit          lattice_spins [0:LAT_ROWS-1][0:LAT_COLS-1];
    logic [6:0]  lattice_rows = 7'd64;
    logic [6:0]  lattice_cols = 7'd64;
    logic [63:0] accept_thr [0:isg_pkg::NUM_THR-1] = '{default: '0};

    // Sites the stimulus has written so far (never read one that is not)
    bit          site_loaded [0:LAT_ROWS-1][0:LAT_COLS-1];

    t_site_cmd    lattice_cmds_q [$];
    t_site_result site_results_q [$];
    t_site_cmd    cur_cmd;

    bit cmd_taken = 1'b0;
    bit quiet = 1'b0;
    int in_gap = 0;
    int out_hold = 0;
    int n_issued = 0;
    int n_errors = 0;

    ising_metropolis_site_update_top #(
        .MAX_ROWS(LAT_ROWS),
        .MAX_COLS(LAT_COLS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_site_row      (i_site_row),
        .i_site_col      (i_site_col),
        .i_spin_value    (i_spin_value),
        .i_random_draw   (i_random_draw),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_spin_after    (o_spin_after),
        .o_flipped       (o_flipped),
        .o_neighbor_total(o_neighbor_total),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Clamp a configured size to the built lattice
    function automatic int eff_dim(logic [6:0] v, int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Apply one command to the lattice model and return the result it gives
    function automatic t_site_result predict_site_result(t_site_cmd c);
        t_site_result res;
        int nr, nc, r, k, rp, rm, cp, cm, ups;
        bit s, flip;
        logic [63:0] pair;
        logic [31:0] thr;
        res = '0;
        nr = eff_dim(lattice_rows, LAT_ROWS);
        nc = eff_dim(lattice_cols, LAT_COLS);
        r = int'(c.row);
        k = int'(c.col);
        if (r >= nr || k >= nc) begin
            res.status = 1'b1;
            return res;
        end
        case (c.op)
            isg_pkg::CMD_WRITE: begin
                lattice_spins[r][k] = c.spin;
                res.spin_after = c.spin;
            end
            isg_pkg::CMD_UPDATE: begin
                rp = (r + 1) % nr;
                rm = (r + nr - 1) % nr;
                cp = (k + 1) % nc;
                cm = (k + nc - 1) % nc;
                ups = int'(lattice_spins[rp][k]) + int'(lattice_spins[rm][k])
                    + int'(lattice_spins[r][cp]) + int'(lattice_spins[r][cm]);
                s = lattice_spins[r][k];
                pair = accept_thr[ups];
                thr = s ? pair[31:0] : pair[63:32];
                flip = ({1'b0, c.draw} < thr);
                if (flip) begin
                    s = ~s;
                end
                lattice_spins[r][k] = s;
                res.spin_after = s;
                res.flipped = flip;
                res.nbr_total = 4'(2 * ups - 4);
            end
            default: begin
                res.spin_after = lattice_spins[r][k];
            end
        endcase
        return res;
    endfunction

    // Gap length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 60) begin
            return 0;
        end else if (k < 88) begin
            return $urandom_range(1, 3);
        end else if (k < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [30:0] pick_draw();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_thr_half();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            4: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Configuration write; the model copy follows at the transfer
    task automatic set_reg(logic [2:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            isg_pkg::CFG_ROWS: lattice_rows = data[6:0];
            isg_pkg::CFG_COLS: lattice_cols = data[6:0];
            isg_pkg::CFG_ACC_M4, isg_pkg::CFG_ACC_M2, isg_pkg::CFG_ACC_ZERO,
            isg_pkg::CFG_ACC_P2, isg_pkg::CFG_ACC_P4:
                accept_thr[idx - isg_pkg::CFG_ACC_M4] = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Size registers carry junk above bit 6, which must be dropped
    task automatic set_size(logic [6:0] rows, logic [6:0] cols);
        set_reg(isg_pkg::CFG_ROWS, ({$urandom, $urandom} & ~64'h7F) | 64'(rows));
        set_reg(isg_pkg::CFG_COLS, ({$urandom, $urandom} & ~64'h7F) | 64'(cols));
        set_reg(CFG_UNMAPPED, {$urandom, $urandom});
    endtask

    task automatic load_thresholds(bit randomise, logic [63:0] fill);
        for (int i = 0; i < isg_pkg::NUM_THR; i++) begin
            set_reg(isg_pkg::CFG_ACC_M4 + 3'(i),
                    randomise ? {pick_thr_half(), pick_thr_half()} : fill);
        end
    endtask

    // Write a random spin to a site that has never been written
    task automatic load_site(int r, int c);
        t_site_cmd w;
        if (!site_loaded[r][c]) begin
            w = '{op: isg_pkg::CMD_WRITE, row: 6'(r), col: 6'(c), spin: 1'($urandom),
                  draw: pick_draw()};
            lattice_cmds_q.push_back(w);
            site_loaded[r][c] = 1'b1;
            n_issued++;
        end
    endtask

    // Queue a command, first loading every spin it would read
    task automatic issue(logic [1:0] op, int r, int c, logic spin, logic [30:0] draw);
        int nr, nc;
        t_site_cmd it;
        nr = eff_dim(lattice_rows, LAT_ROWS);
        nc = eff_dim(lattice_cols, LAT_COLS);
        if (r < nr && c < nc) begin
            if (op == isg_pkg::CMD_UPDATE) begin
                load_site((r + 1) % nr, c);
                load_site((r + nr - 1) % nr, c);
                load_site(r, (c + 1) % nc);
                load_site(r, (c + nc - 1) % nc);
                load_site(r, c);
            end else if (op != isg_pkg::CMD_WRITE) begin
                load_site(r, c);
            end else begin
                site_loaded[r][c] = 1'b1;
            end
        end
        it = '{op: op, row: 6'(r), col: 6'(c), spin: spin, draw: draw};
        lattice_cmds_q.push_back(it);
        n_issued++;
    endtask

    task automatic random_phase(int n_items);
        int start, nr, nc, r, c, sel;
        logic [1:0] op;
        start = n_issued;
        nr = eff_dim(lattice_rows, LAT_ROWS);
        nc = eff_dim(lattice_cols, LAT_COLS);
        while (n_issued - start < n_items) begin
            if (nr == 0 || $urandom_range(0, 9) == 0) begin
                r = $urandom_range(0, 63);
            end else begin
                r = $urandom_range(0, nr - 1);
            end
            if (nc == 0 || $urandom_range(0, 9) == 0) begin
                c = $urandom_range(0, 63);
            end else begin
                c = $urandom_range(0, nc - 1);
            end
            sel = $urandom_range(0, 99);
            if (sel < 62) begin
                op = isg_pkg::CMD_UPDATE;
            end else if (sel < 78) begin
                op = isg_pkg::CMD_WRITE;
            end else if (sel < 92) begin
                op = isg_pkg::CMD_READ;
            end else begin
                op = CMD_SPARE;
            end
            issue(op, r, c, 1'($urandom), pick_draw());
        end
    endtask

    // Hold until every queued command has transferred and every result is in
    task automatic wait_drained();
        while (lattice_cmds_q.size() != 0 || i_in_valid || site_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Command driver: advance on a transfer, hold while stalled
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || cmd_taken)) begin
            cmd_taken = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (lattice_cmds_q.size() > 0) begin
                cur_cmd = lattice_cmds_q.pop_front();
                i_command <= cur_cmd.op;
                i_site_row <= cur_cmd.row;
                i_site_col <= cur_cmd.col;
                i_spin_value <= cur_cmd.spin;
                i_random_draw <= cur_cmd.draw;
                i_in_valid <= 1'b1;
                in_gap = pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            out_hold = pick_gap();
        end
    end

    // Monitor: predict on each command transfer, check each result transfer
    always @(posedge i_clk) begin : monitor
        t_site_result got, want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                site_results_q.push_back(predict_site_result(cur_cmd));
                cmd_taken = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                got = {o_spin_after, o_flipped, o_neighbor_total, o_status};
                if (site_results_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("unexpected result: spin %0d flip %0d sum %0d status %0d",
                                 got.spin_after, got.flipped, got.nbr_total, got.status);
                    end
                end else begin
                    want = site_results_q.pop_front();
                    if (got !== want) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("result differs: expected spin %0d flip %0d sum %0d status %0d",
                                     want.spin_after, want.flipped, want.nbr_total, want.status);
                            $display("                got      spin %0d flip %0d sum %0d status %0d",
                                     got.spin_after, got.flipped, got.nbr_total, got.status);
                        end
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: 64 x 64, all thresholds zero so nothing flips
        issue(isg_pkg::CMD_WRITE, 63, 63, 1'b1, '0);
        issue(isg_pkg::CMD_READ, 63, 63, 1'b0, '0);
        issue(CMD_SPARE, 63, 63, 1'b1, '1);
        issue(isg_pkg::CMD_WRITE, 0, 0, 1'b0, '0);
        issue(isg_pkg::CMD_UPDATE, 0, 0, 1'b0, '1);
        issue(isg_pkg::CMD_UPDATE, 0, 0, 1'b1, '0);
        wait_drained();

        // One-site lattice: the site is its own neighbour; 2^31 always accepts
        set_size(7'd1, 7'd1);
        load_thresholds(1'b0, 64'h8000_0000_8000_0000);
        issue(isg_pkg::CMD_UPDATE, 0, 0, 1'b0, '1);
        issue(isg_pkg::CMD_UPDATE, 0, 0, 1'b1, '0);
        issue(isg_pkg::CMD_WRITE, 0, 1, 1'b1, '0);
        issue(isg_pkg::CMD_READ, 1, 0, 1'b0, '0);
        wait_drained();

        // Zero rows: every site lies outside
        set_size(7'd0, 7'd127);
        issue(isg_pkg::CMD_WRITE, 0, 0, 1'b1, '0);
        issue(isg_pkg::CMD_UPDATE, 5, 5, 1'b0, '0);
        wait_drained();

        // Oversized settings saturate to the built lattice
        set_size(7'd127, 7'd127);
        issue(isg_pkg::CMD_READ, 63, 63, 1'b0, '0);
        issue(isg_pkg::CMD_UPDATE, 63, 63, 1'b1, '1);
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: set_size(7'd2, 7'd2);
                1: set_size(7'd64, 7'd64);
                2: set_size(7'd127, 7'd65);
                3: set_size(7'd1, 7'($urandom_range(2, 64)));
                default: set_size(7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)));
            endcase
            load_thresholds(1'b1, '0);
            quiet = (p % 3 == 1);
            random_phase((ITEM_GOAL - n_issued) / (N_PHASES - p));
            wait_drained();
        end

        quiet = 1'b0;
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("ising_metropolis_site_update_top: match");
        end else begin
            $display("ising_metropolis_site_update_top: mismatch");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("ising_metropolis_site_update_top: mismatch");
        $finish;
    end

endmodule
